>>> rtl/core/bit32_logic_shift_field_unit_defines.svh
// Assertion macros for the bit32 logic, shift and field unit.
// Included by the RTL files that carry concurrent assertions; expects clk and arst_n in scope.
`ifndef BIT32_LOGIC_SHIFT_FIELD_UNIT_DEFINES_SVH
`define BIT32_LOGIC_SHIFT_FIELD_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, switched off while reset is asserted.
`define B32_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, switched off while reset is asserted.
`define B32_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/b32lsf_pkg.sv
// Package for the bit32 logic, shift and field unit: command and error codes,
// field widths and the shift and rotate helpers. Depends on nothing.
`default_nettype none

package b32lsf_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned CNT_W   = 7;
	localparam int unsigned CMD_W   = 4;
	localparam int unsigned ERR_W   = 2;
	localparam int unsigned IN_DATA_W  = 88;
	localparam int unsigned OUT_DATA_W = 40;

	localparam logic [WORD_W-1:0] WORD_ONES = 32'hFFFF_FFFF;

	typedef enum logic [CMD_W-1:0] {
		CMD_AND     = 4'd0,
		CMD_OR      = 4'd1,
		CMD_XOR     = 4'd2,
		CMD_TEST    = 4'd3,
		CMD_NOT     = 4'd4,
		CMD_LSHIFT  = 4'd5,
		CMD_RSHIFT  = 4'd6,
		CMD_ARSHIFT = 4'd7,
		CMD_LROTATE = 4'd8,
		CMD_RROTATE = 4'd9,
		CMD_EXTRACT = 4'd10,
		CMD_REPLACE = 4'd11
	} cmd_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK       = 2'd0,
		ERR_POSITION = 2'd1,
		ERR_WIDTH    = 2'd2,
		ERR_EXTENT   = 2'd3
	} err_t;

	// Logical left shift by an 8-bit unsigned count; 32 or more clears the word.
	function automatic logic [WORD_W-1:0] shl32(input logic [WORD_W-1:0] x,
			input logic [7:0] n);
		shl32 = (n >= 8'd32) ? '0 : (x << n[4:0]);
	endfunction

	// Logical right shift by an 8-bit unsigned count; 32 or more clears the word.
	function automatic logic [WORD_W-1:0] shr32(input logic [WORD_W-1:0] x,
			input logic [7:0] n);
		shr32 = (n >= 8'd32) ? '0 : (x >> n[4:0]);
	endfunction

	// Left rotate by a count taken modulo 32.
	function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
			input logic [4:0] n);
		rotl32 = (n == 5'd0) ? x : ((x << n) | (x >> (6'd32 - {1'b0, n})));
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/bit32_logic_shift_field_unit.sv
// Top level of the bit32 logic, shift and field unit: input register, combinational
// operation logic and output register. Depends on b32lsf_pkg and the assertion header.
//
// Usage:
//   Input channel s_*: one word per command. s_tuser carries the command code, s_tdata
//   the operands. Output channel m_*: one word per accepted command, in order, holding
//   the 32-bit result and a 2-bit error code (nonzero only for extract and replace).
//   Path: an accepted word is held in the input register; its result is then written
//   into the output register, which drives m_tdata, unless that register is full and
//   not being read. Throughput: one word per cycle while m_tready stays high. Only
//   the input register and the output register hold an item; the operation itself is
//   one pass of logic between them.
//   Stalls: when m_tready is low the output register holds its word; the input register
//   may still fill, and s_tready drops only once both registers are occupied.
//   Reset: arst_n clears both valid flags asynchronously; no word is lost or produced
//   by reset other than words still in flight, which are dropped.
`default_nettype none

`include "bit32_logic_shift_field_unit_defines.svh"

module bit32_logic_shift_field_unit
	import b32lsf_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output      logic                  s_tready,
	// Fields from bit 0 up: value_a[31:0], value_b[63:32], displacement[70:64],
	// field_position[77:71], field_width[84:78], zero padding[87:85].
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// Fields from bit 0 up: command[3:0].
	input  wire logic [CMD_W-1:0]      s_tuser,
	output      logic                  m_tvalid,
	input  wire logic                  m_tready,
	// Fields from bit 0 up: result_word[31:0], error_code[33:32], zero padding[39:34].
	output      logic [OUT_DATA_W-1:0] m_tdata
);

	// Input register stage.
	logic                     valid_s1;
	cmd_t                     cmd_s1;
	logic [WORD_W-1:0]        a_s1;
	logic [WORD_W-1:0]        b_s1;
	logic signed [CNT_W-1:0]  disp_s1;
	logic signed [CNT_W-1:0]  pos_s1;
	logic signed [CNT_W-1:0]  width_s1;

	// Output register stage.
	logic                     valid_s2;
	logic [WORD_W-1:0]        result_s2;
	err_t                     error_s2;

	logic                     advance_s2;

	// Operation logic.
	logic signed [7:0]        disp_ext_c;
	logic signed [7:0]        lsh_cnt_c;
	logic [7:0]               lsh_mag_c;
	logic [7:0]               ars_mag_c;
	logic [4:0]               rot_cnt_c;
	logic [6:0]               fld_end_c;
	logic [5:0]               fld_shift_c;
	logic [WORD_W-1:0]        fld_mask_c;
	err_t                     fld_err_c;
	logic [WORD_W-1:0]        result_c;
	err_t                     error_c;

	// The output register takes a new word whenever it is empty or being read.
	assign advance_s2 = !valid_s2 || m_tready;
	assign s_tready   = !valid_s1 || advance_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1   <= cmd_t'(s_tuser);
			a_s1     <= s_tdata[31:0];
			b_s1     <= s_tdata[63:32];
			disp_s1  <= s_tdata[70:64];
			pos_s1   <= s_tdata[77:71];
			width_s1 <= s_tdata[84:78];
		end
	end

	// Shift counts. A right shift is a left shift by the negated count, so the
	// count is widened to eight bits to hold the negation of -64.
	always_comb begin
		disp_ext_c = {disp_s1[CNT_W-1], disp_s1};
		lsh_cnt_c  = (cmd_s1 == CMD_RSHIFT) ? -disp_ext_c : disp_ext_c;
		lsh_mag_c  = lsh_cnt_c[7] ? -lsh_cnt_c : lsh_cnt_c;
		ars_mag_c  = disp_ext_c[7] ? -disp_ext_c : disp_ext_c;
		rot_cnt_c  = (cmd_s1 == CMD_RROTATE) ? -disp_s1[4:0] : disp_s1[4:0];
	end

	// Field checks in order: position, width, then extent past bit 31. Once position
	// and width pass, both are non-negative and fit in six bits.
	always_comb begin
		fld_end_c   = {1'b0, pos_s1[5:0]} + {1'b0, width_s1[5:0]};
		fld_shift_c = 6'd32 - width_s1[5:0];
		fld_mask_c  = WORD_ONES >> fld_shift_c;
		if (pos_s1[CNT_W-1]) begin
			fld_err_c = ERR_POSITION;
		end else if (width_s1[CNT_W-1] || (width_s1 == '0)) begin
			fld_err_c = ERR_WIDTH;
		end else if (fld_end_c > 7'd32) begin
			fld_err_c = ERR_EXTENT;
		end else begin
			fld_err_c = ERR_OK;
		end
	end

	always_comb begin
		result_c = '0;
		error_c  = ERR_OK;
		unique case (cmd_s1)
			CMD_AND: begin
				result_c = a_s1 & b_s1;
			end
			CMD_OR: begin
				result_c = a_s1 | b_s1;
			end
			CMD_XOR: begin
				result_c = a_s1 ^ b_s1;
			end
			CMD_TEST: begin
				result_c = {{(WORD_W-1){1'b0}}, |(a_s1 & b_s1)};
			end
			CMD_NOT: begin
				result_c = ~a_s1;
			end
			CMD_LSHIFT, CMD_RSHIFT: begin
				result_c = lsh_cnt_c[7] ? shr32(a_s1, lsh_mag_c) : shl32(a_s1, lsh_mag_c);
			end
			CMD_ARSHIFT: begin
				// A negative count shifts left; a count of 32 or more fills with the sign.
				if (disp_ext_c[7]) begin
					result_c = shl32(a_s1, ars_mag_c);
				end else if (ars_mag_c >= 8'd32) begin
					result_c = {WORD_W{a_s1[WORD_W-1]}};
				end else begin
					result_c = $unsigned($signed(a_s1) >>> ars_mag_c[4:0]);
				end
			end
			CMD_LROTATE, CMD_RROTATE: begin
				result_c = rotl32(a_s1, rot_cnt_c);
			end
			CMD_EXTRACT: begin
				error_c = fld_err_c;
				if (fld_err_c == ERR_OK) begin
					result_c = (a_s1 >> pos_s1[4:0]) & fld_mask_c;
				end
			end
			CMD_REPLACE: begin
				error_c = fld_err_c;
				if (fld_err_c == ERR_OK) begin
					result_c = (a_s1 & ~(fld_mask_c << pos_s1[4:0]))
						| ((b_s1 & fld_mask_c) << pos_s1[4:0]);
				end
			end
			default: begin
				result_c = '0;
				error_c  = ERR_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance_s2) begin
			result_s2 <= result_c;
			error_s2  <= error_c;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OUT_DATA_W-WORD_W-ERR_W){1'b0}}, error_s2, result_s2};

	`B32_ASSERT_NXT(a_accept_fills_s1, s_tvalid && s_tready, valid_s1,
		"accepted word did not reach the input register")
	`B32_ASSERT_IMP(a_ready_only_when_full, !s_tready, valid_s1 && valid_s2 && !m_tready,
		"input stalled while a register was free")
	`B32_ASSERT_IMP(a_error_only_on_field,
		valid_s1 && cmd_s1 != CMD_EXTRACT && cmd_s1 != CMD_REPLACE, error_c == ERR_OK,
		"error code raised by a command other than extract or replace")
	`B32_ASSERT_IMP(a_error_clears_result, valid_s2 && error_s2 != ERR_OK, result_s2 == '0,
		"field error with a nonzero result word")

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for bit32_logic_shift_field_unit: streams commands into the unit
// and compares every result word with a predictor of the bit32 logic, shift and field rules.
// Depends on b32lsf_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_top
	import b32lsf_pkg::*;
();

	// Command codes 12 to 15 are not assigned; the unit must answer them with a zero word.
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd12;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

	localparam int RANDOM_OPS    = 850;
	localparam int STALL_PERCENT = 12;
	localparam int HANG_LIMIT    = 2000;
	localparam int DRAIN_CYCLES  = 8;

	typedef struct {
		logic [CMD_W-1:0]         command;
		logic [WORD_W-1:0]        value_a;
		logic [WORD_W-1:0]        value_b;
		logic signed [CNT_W-1:0]  displacement;
		logic signed [CNT_W-1:0]  field_position;
		logic signed [CNT_W-1:0]  field_width;
	} bitop_req_t;

	typedef struct {
		logic [WORD_W-1:0] word;
		logic [ERR_W-1:0]  err;
	} bitop_res_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// Fields from bit 0 up: value_a, value_b, displacement, field_position, field_width, padding.
	logic [IN_DATA_W-1:0]  s_tdata;
	// Fields from bit 0 up: command.
	logic [CMD_W-1:0]      s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// Fields from bit 0 up: result_word, error_code, padding.
	logic [OUT_DATA_W-1:0] m_tdata;

	bitop_req_t pending_ops[$];
	bitop_res_t expected_results[$];
	bitop_req_t word_on_bus;
	bit         word_taken;
	bit         running;
	int         ops_queued;
	int         ops_accepted;
	int         results_seen;
	int         mismatch_count;
	int         quiet_cycles;

	bit32_logic_shift_field_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shift left by a signed count; a negative count shifts right, 32 or more clears the word.
	function automatic logic [WORD_W-1:0] shift_signed(logic [WORD_W-1:0] x, int d);
		if (d < 0)
			return (-d >= 32) ? '0 : (x >> -d);
		return (d >= 32) ? '0 : (x << d);
	endfunction

	function automatic logic [WORD_W-1:0] rotate_left(logic [WORD_W-1:0] x, logic [4:0] n);
		if (n == 5'd0)
			return x;
		return (x << n) | (x >> (6'd32 - {1'b0, n}));
	endfunction

	// Expected result of one command, following the bit32 library rules on 32-bit words.
	function automatic bitop_res_t predict_bitop(bitop_req_t req);
		bitop_res_t          res;
		int                  d;
		int                  neg_d;
		int                  pos;
		int                  wid;
		logic [WORD_W-1:0]   mask;
		logic signed [31:0]  sword;
		d = int'(req.displacement);
		neg_d = -d;
		pos = int'(req.field_position);
		wid = int'(req.field_width);
		sword = req.value_a;
		res.word = '0;
		res.err = ERR_OK;
		case (req.command)
			CMD_AND:     res.word = req.value_a & req.value_b;
			CMD_OR:      res.word = req.value_a | req.value_b;
			CMD_XOR:     res.word = req.value_a ^ req.value_b;
			CMD_TEST:    res.word = ((req.value_a & req.value_b) != '0) ? 32'd1 : 32'd0;
			CMD_NOT:     res.word = ~req.value_a;
			CMD_LSHIFT:  res.word = shift_signed(req.value_a, d);
			CMD_RSHIFT:  res.word = shift_signed(req.value_a, neg_d);
			CMD_ARSHIFT: begin
				// A negative count is a plain left shift; a long count leaves only sign bits.
				if (d < 0)
					res.word = shift_signed(req.value_a, neg_d);
				else if (d >= 32)
					res.word = {WORD_W{req.value_a[WORD_W-1]}};
				else
					res.word = sword >>> d;
			end
			CMD_LROTATE: res.word = rotate_left(req.value_a, d[4:0]);
			CMD_RROTATE: res.word = rotate_left(req.value_a, neg_d[4:0]);
			CMD_EXTRACT, CMD_REPLACE: begin
				// Position is checked first, then width, then the upper end of the field.
				if (pos < 0) begin
					res.err = ERR_POSITION;
				end else if (wid <= 0) begin
					res.err = ERR_WIDTH;
				end else if (pos + wid > 32) begin
					res.err = ERR_EXTENT;
				end else begin
					mask = WORD_ONES >> (32 - wid);
					if (req.command == CMD_EXTRACT)
						res.word = (req.value_a >> pos) & mask;
					else
						res.word = (req.value_a & ~(mask << pos)) |
							((req.value_b & mask) << pos);
				end
			end
			default: res.word = '0;
		endcase
		return res;
	endfunction

	task automatic queue_op(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
			int d, int pos, int wid);
		bitop_req_t req;
		req.command = cmd;
		req.value_a = a;
		req.value_b = b;
		req.displacement = CNT_W'(d);
		req.field_position = CNT_W'(pos);
		req.field_width = CNT_W'(wid);
		pending_ops.push_back(req);
		ops_queued++;
	endtask

	// Random commands. Field commands mostly get a legal field so that the extract and
	// replace datapath is exercised; the rest use any 7-bit pattern to hit the error codes.
	task automatic queue_random_ops(int count);
		logic [CMD_W-1:0]  cmd;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		int                d;
		int                pos;
		int                wid;
		for (int i = 0; i < count; i++) begin
			cmd = CMD_W'(($urandom_range(0, 99) < 3) ? $urandom_range(12, 15) :
				$urandom_range(0, 11));
			case ($urandom_range(0, 19))
				0:       a = '0;
				1:       a = WORD_ONES;
				2:       a = 32'h8000_0000;
				3:       a = 32'h7FFF_FFFF;
				default: a = $urandom;
			endcase
			b = $urandom;
			if (cmd == CMD_TEST && $urandom_range(0, 3) == 0)
				b = ~a;
			if ($urandom_range(0, 3) != 0)
				d = int'($urandom_range(0, 80)) - 40;
			else
				d = int'($urandom_range(0, 127)) - 64;
			if ($urandom_range(0, 4) != 0) begin
				pos = $urandom_range(0, 31);
				wid = $urandom_range(1, 32 - pos);
			end else begin
				pos = int'($urandom_range(0, 127)) - 64;
				wid = int'($urandom_range(0, 127)) - 64;
			end
			queue_op(cmd, a, b, d, pos, wid);
		end
	endtask

	// Input side: present the next pending word whenever the bus is free or the last
	// word was just taken. Between accepted words 300 and 450 the sender never pauses.
	always @(negedge clk) begin
		if (running && (!s_tvalid || word_taken)) begin
			if (pending_ops.size() > 0 &&
					((ops_accepted >= 300 && ops_accepted < 450) ||
					$urandom_range(0, 99) >= STALL_PERCENT)) begin
				word_on_bus = pending_ops.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= word_on_bus.command;
				s_tdata  <= {3'b000, word_on_bus.field_width, word_on_bus.field_position,
					word_on_bus.displacement, word_on_bus.value_b, word_on_bus.value_a};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		word_taken = 1'b0;
		// Output side: back-pressure at random, except for a quiet stretch of results.
		m_tready <= running && ((results_seen >= 500 && results_seen < 650) ||
			$urandom_range(0, 99) >= STALL_PERCENT);
	end

	// Both handshakes are observed at the rising edge. An accepted command is predicted
	// at once; an accepted result is checked against the oldest prediction.
	always @(posedge clk) begin : result_check
		bitop_res_t want;
		if (running) begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(predict_bitop(word_on_bus));
				ops_accepted++;
				word_taken = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$display("%0t: result word %h with no command outstanding",
						$time, m_tdata);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[WORD_W-1:0] !== want.word) begin
						$display("%0t: result_word expected %h, got %h",
							$time, want.word, m_tdata[WORD_W-1:0]);
						mismatch_count++;
					end
					if (m_tdata[WORD_W+ERR_W-1:WORD_W] !== want.err) begin
						$display("%0t: error_code expected %0d, got %0d",
							$time, want.err, m_tdata[WORD_W+ERR_W-1:WORD_W]);
						mismatch_count++;
					end
				end
			end
		end
		running = arst_n;
	end

	// Hang detection: too many cycles in a row with no word moving on either side.
	always @(posedge clk) begin
		if (running) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		word_taken = 1'b0;
		running = 1'b0;
		ops_queued = 0;
		ops_accepted = 0;
		results_seen = 0;
		mismatch_count = 0;
		quiet_cycles = 0;

		// Directed words: operand extremes, every command, count and field corner cases.
		queue_op(CMD_AND,     WORD_ONES, 32'h0F0F_F0F0, 0, 0, 0);
		queue_op(CMD_OR,      32'h0000_0000, 32'h8000_0001, 0, 0, 0);
		queue_op(CMD_XOR,     WORD_ONES, 32'hA5A5_5A5A, 0, 0, 0);
		queue_op(CMD_TEST,    32'hF0F0_0000, 32'h0F0F_FFFF, 0, 0, 0);
		queue_op(CMD_TEST,    32'h8000_0000, WORD_ONES, 0, 0, 0);
		queue_op(CMD_NOT,     32'h0000_0000, 32'h0, 0, 0, 0);
		queue_op(CMD_LSHIFT,  32'h8000_0001, 32'h0, 31, 0, 0);
		queue_op(CMD_LSHIFT,  WORD_ONES, 32'h0, -64, 0, 0);
		queue_op(CMD_LSHIFT,  WORD_ONES, 32'h0, 32, 0, 0);
		queue_op(CMD_RSHIFT,  32'h8000_0001, 32'h0, -31, 0, 0);
		queue_op(CMD_RSHIFT,  WORD_ONES, 32'h0, 63, 0, 0);
		queue_op(CMD_ARSHIFT, 32'h8000_0000, 32'h0, 63, 0, 0);
		queue_op(CMD_ARSHIFT, 32'h8765_4321, 32'h0, 4, 0, 0);
		queue_op(CMD_ARSHIFT, 32'h8765_4321, 32'h0, -4, 0, 0);
		queue_op(CMD_ARSHIFT, 32'h7FFF_FFFF, 32'h0, 40, 0, 0);
		queue_op(CMD_LROTATE, 32'h8000_0001, 32'h0, -1, 0, 0);
		queue_op(CMD_RROTATE, 32'h1234_5678, 32'h0, 36, 0, 0);
		queue_op(CMD_EXTRACT, WORD_ONES, 32'h0, 0, 0, 32);
		queue_op(CMD_EXTRACT, 32'hDEAD_BEEF, 32'h0, 0, 63, -64);
		queue_op(CMD_REPLACE, 32'hDEAD_BEEF, 32'h0, 0, -64, 63);
		queue_op(CMD_REPLACE, 32'hDEAD_BEEF, 32'h1, 0, 4, 0);
		queue_op(CMD_EXTRACT, 32'hDEAD_BEEF, 32'h0, 0, 31, 2);
		queue_op(CMD_REPLACE, 32'h0000_0000, WORD_ONES, 0, 31, 1);
		queue_op(CMD_SPARE_LO, WORD_ONES, WORD_ONES, -1, -1, -1);
		queue_op(CMD_SPARE_HI, WORD_ONES, WORD_ONES, 63, 63, 63);
		queue_random_ops(RANDOM_OPS);

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		while (ops_accepted < ops_queued)
			@(negedge clk);
		while (expected_results.size() != 0)
			@(negedge clk);
		// A little extra time so that a spurious trailing result would still be caught.
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
